// ----- sv/dll_pkg.sv -----
// Shared constants, types and codes for the linked list engine.
package dll_pkg;

   // Node store size and the widths that follow from it.
   localparam int CAPACITY = 64;
   localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;

   typedef logic [SLOT_W-1:0]         slot_type;
   typedef logic [CNT_W-1:0]          count_type;
   typedef logic signed [VALUE_W-1:0] value_type;

   localparam count_type FULL_COUNT = count_type'(CAPACITY);

   // Operation codes of a request transaction.
   typedef enum logic [1:0] {
      KIND_PUSH_FRONT = 2'd0,
      KIND_PUSH_BACK  = 2'd1,
      KIND_REMOVE     = 2'd2,
      KIND_SEARCH     = 2'd3
   } kind_type;

   // Status codes of a response transaction.
   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_MISS = 2'd2
   } status_type;

endpackage

// ----- sv/dll_if.sv -----
// Request and response channel interfaces of the linked list engine.
interface dll_req_if;
   logic               valid;
   logic               ready;
   dll_pkg::kind_type  kind;
   dll_pkg::value_type value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

interface dll_rsp_if;
   logic                 valid;
   logic                 ready;
   dll_pkg::status_type  status;
   dll_pkg::count_type   pos_from_head;
   dll_pkg::count_type   pos_from_tail;
   dll_pkg::count_type   entry_total;

   modport source (output valid, output status, output pos_from_head,
                   output pos_from_tail, output entry_total, input ready);
   modport sink   (input valid, input status, input pos_from_head,
                   input pos_from_tail, input entry_total, output ready);
endinterface

// ----- sv/dll_ram.sv -----
// Generic single-write, single-read memory with a registered read port.
module dll_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- sv/doubly_linked_list_engine.sv -----
// Top level of the linked list engine: sequencer and node store memories.
//
// Usage: one request transaction (kind, value) on req yields exactly one
// response transaction (status, pos_from_head, pos_from_tail, entry_total)
// on rsp, in order. Requests are taken one at a time; req.ready is high
// whenever the sequencer is idle, even while a finished response waits.
// Steps from the accepting edge to the response register:
//   push:          ST_SCAN checks one used bit per cycle and writes the
//                  node into the lowest free slot, then ST_LINK links the
//                  old end node to it (skipped onto an empty list); a full
//                  store goes straight to ST_FINISH;
//   remove/search: ST_WALK visits one node per cycle, since each step
//                  follows the next link read from the memory; an empty
//                  list goes straight to ST_FINISH.
// ST_FINISH loads the response and returns to ST_IDLE for the next request.
// Node values and links live in three memories with a registered read.
// Reset (synchronous) empties the list and clears all used bits at once;
// no clearing pass is needed. If the receiver stalls, the response holds
// in the output register and the next finished result waits behind it.
module doubly_linked_list_engine (
   input  logic        clock,
   input  logic        reset,
   dll_req_if.sink     req,
   dll_rsp_if.source   rsp
);
   import dll_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LINK,
      ST_WALK,
      ST_FINISH
   } state_type;

   // Control registers.
   state_type             state_ff, state_in;
   logic [CAPACITY-1:0]   slot_used_ff, slot_used_in;
   slot_type              head_ff, head_in;
   slot_type              tail_ff, tail_in;
   count_type             count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Working registers of the current transaction.
   kind_type              kind_ff, kind_in;
   value_type             value_ff, value_in;
   slot_type              scan_ff, scan_in;
   slot_type              cur_ff, cur_in;
   count_type             pos_ff, pos_in;
   slot_type              free_ff, free_in;
   slot_type              link_ff, link_in;
   status_type            res_status_ff, res_status_in;
   count_type             res_ph_ff, res_ph_in;
   count_type             res_pt_ff, res_pt_in;

   // Response payload registers.
   status_type            rsp_status_ff, rsp_status_in;
   count_type             rsp_ph_ff, rsp_ph_in;
   count_type             rsp_pt_ff, rsp_pt_in;
   count_type             rsp_total_ff, rsp_total_in;

   // Memory ports.
   logic                  val_we, prev_we, next_we;
   slot_type              val_wa, prev_wa, next_wa;
   value_type             val_wd;
   slot_type              prev_wd, next_wd;
   slot_type              rd_addr;
   value_type             val_rd;
   slot_type              prev_rd, next_rd;
   logic                  is_front;

   dll_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_wa),
      .wr_data (val_wd),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   dll_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_addr (rd_addr),
      .rd_data (prev_rd)
   );

   dll_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_addr (rd_addr),
      .rd_data (next_rd)
   );

   // During a walk the next node is fetched straight from the read data.
   assign rd_addr  = (state_ff == ST_WALK) ? next_rd : head_ff;
   assign is_front = (kind_ff == KIND_PUSH_FRONT);

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.pos_from_head = rsp_ph_ff;
   assign rsp.pos_from_tail = rsp_pt_ff;
   assign rsp.entry_total   = rsp_total_ff;

   // Sequencer next-state and memory control.
   always_comb begin
      state_in      = state_ff;
      slot_used_in  = slot_used_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      scan_in       = scan_ff;
      cur_in        = cur_ff;
      pos_in        = pos_ff;
      free_in       = free_ff;
      link_in       = link_ff;
      res_status_in = res_status_ff;
      res_ph_in     = res_ph_ff;
      res_pt_in     = res_pt_ff;
      rsp_status_in = rsp_status_ff;
      rsp_ph_in     = rsp_ph_ff;
      rsp_pt_in     = rsp_pt_ff;
      rsp_total_in  = rsp_total_ff;

      val_we  = 1'b0;
      val_wa  = scan_ff;
      val_wd  = value_ff;
      prev_we = 1'b0;
      prev_wa = scan_ff;
      prev_wd = '0;
      next_we = 1'b0;
      next_wa = scan_ff;
      next_wd = '0;

      // The output register empties when the receiver takes it.
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            res_ph_in = '0;
            res_pt_in = '0;
            if (req.valid) begin
               kind_in  = req.kind;
               value_in = req.value;
               if (req.kind == KIND_PUSH_FRONT || req.kind == KIND_PUSH_BACK) begin
                  if (count_ff == FULL_COUNT) begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_FINISH;
                  end else begin
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end
               end else if (count_ff == '0) begin
                  res_status_in = STATUS_MISS;
                  state_in      = ST_FINISH;
               end else begin
                  cur_in   = head_ff;
                  pos_in   = count_type'(1);
                  state_in = ST_WALK;
               end
            end
         end

         ST_SCAN: begin
            // Check one used bit per cycle; the first clear one takes the node.
            if (!slot_used_ff[scan_ff]) begin
               val_we  = 1'b1;
               prev_we = 1'b1;
               prev_wd = is_front ? slot_type'(0) : tail_ff;
               next_we = 1'b1;
               next_wd = is_front ? head_ff : slot_type'(0);
               slot_used_in[scan_ff] = 1'b1;
               count_in      = count_type'(count_ff + 1'b1);
               free_in       = scan_ff;
               link_in       = is_front ? head_ff : tail_ff;
               res_status_in = STATUS_OK;
               if (is_front) begin
                  head_in = scan_ff;
                  if (count_ff == '0) begin
                     tail_in = scan_ff;
                  end
               end else begin
                  tail_in = scan_ff;
                  if (count_ff == '0) begin
                     head_in = scan_ff;
                  end
               end
               state_in = (count_ff != '0) ? ST_LINK : ST_FINISH;
            end else begin
               scan_in = slot_type'(scan_ff + 1'b1);
            end
         end

         ST_LINK: begin
            // Point the old end node at the new one.
            if (is_front) begin
               prev_we = 1'b1;
               prev_wa = link_ff;
               prev_wd = free_ff;
            end else begin
               next_we = 1'b1;
               next_wa = link_ff;
               next_wd = free_ff;
            end
            state_in = ST_FINISH;
         end

         ST_WALK: begin
            // Read data holds the node at cur_ff, position pos_ff.
            if (val_rd == value_ff) begin
               res_status_in = STATUS_OK;
               if (kind_ff == KIND_SEARCH) begin
                  res_ph_in = pos_ff;
                  res_pt_in = count_type'(count_ff - pos_ff + 1'b1);
               end else begin
                  if (pos_ff == count_type'(1)) begin
                     head_in = next_rd;
                  end else begin
                     next_we = 1'b1;
                     next_wa = prev_rd;
                     next_wd = next_rd;
                  end
                  if (pos_ff == count_ff) begin
                     tail_in = prev_rd;
                  end else begin
                     prev_we = 1'b1;
                     prev_wa = next_rd;
                     prev_wd = prev_rd;
                  end
                  slot_used_in[cur_ff] = 1'b0;
                  count_in = count_type'(count_ff - 1'b1);
               end
               state_in = ST_FINISH;
            end else if (pos_ff == count_ff) begin
               res_status_in = STATUS_MISS;
               state_in      = ST_FINISH;
            end else begin
               cur_in = next_rd;
               pos_in = count_type'(pos_ff + 1'b1);
            end
         end

         ST_FINISH: begin
            // Load the response once the output register is free.
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_ph_in     = res_ph_ff;
               rsp_pt_in     = res_pt_ff;
               rsp_total_in  = count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_used_ff <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_used_ff <= slot_used_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      scan_ff       <= scan_in;
      cur_ff        <= cur_in;
      pos_ff        <= pos_in;
      free_ff       <= free_in;
      link_ff       <= link_in;
      res_status_ff <= res_status_in;
      res_ph_ff     <= res_ph_in;
      res_pt_ff     <= res_pt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ph_ff     <= rsp_ph_in;
      rsp_pt_ff     <= rsp_pt_in;
      rsp_total_ff  <= rsp_total_in;
   end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the doubly linked list engine.
`timescale 1ns / 1ps

module tb;
   import dll_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 2000;
   localparam int PHASE_ITEMS  = 250;
   localparam int LONG_HOLD    = 400;
   localparam int POOL_SIZE    = 12;

   // One expected response transaction.
   typedef struct packed {
      status_type status;
      count_type  pos_from_head;
      count_type  pos_from_tail;
      count_type  entry_total;
   } list_result_type;

   logic clock;
   logic reset;

   dll_req_if req_bus ();
   dll_rsp_if rsp_bus ();

   doubly_linked_list_engine u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // Predicted list contents, kept in the same slot layout as the block.
   value_type list_value [CAPACITY];
   int        list_prev  [CAPACITY];
   int        list_next  [CAPACITY];
   bit        slot_taken [CAPACITY];
   int        list_head;
   int        list_tail;
   int        list_count;

   list_result_type pending_results [$];
   value_type       value_pool [POOL_SIZE];

   int  error_count;
   int  items_sent;
   int  results_checked;
   int  full_seen;
   int  miss_seen;
   int  hit_seen;
   int  cycle_count;
   int  long_holds_asked;
   bit  no_idle;

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Apply one operation to the predicted list and return its response.
   function automatic list_result_type apply_list_op(input kind_type kind, input value_type v);
      list_result_type r;
      int free_slot;
      int s;
      int hit_pos;
      int hit_slot;
      int p;
      int n;
      r.status        = STATUS_OK;
      r.pos_from_head = '0;
      r.pos_from_tail = '0;
      free_slot = CAPACITY;
      hit_pos   = 0;
      hit_slot  = 0;
      if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) begin
         // A new node takes the lowest unused slot.
         for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!slot_taken[i]) free_slot = i;
         end
         if (free_slot == CAPACITY) begin
            r.status = STATUS_FULL;
         end else begin
            list_value[free_slot] = v;
            slot_taken[free_slot] = 1'b1;
            if (kind == KIND_PUSH_FRONT) begin
               list_prev[free_slot] = 0;
               list_next[free_slot] = list_head;
               if (list_count != 0) list_prev[list_head] = free_slot;
               else list_tail = free_slot;
               list_head = free_slot;
            end else begin
               list_next[free_slot] = 0;
               list_prev[free_slot] = list_tail;
               if (list_count != 0) list_next[list_tail] = free_slot;
               else list_head = free_slot;
               list_tail = free_slot;
            end
            list_count++;
         end
      end else begin
         // Walk from the head; the walk never passes the last entry.
         s = list_head;
         for (int pos = 1; pos <= list_count && hit_pos == 0; pos++) begin
            if (list_value[s] == v) begin
               hit_pos  = pos;
               hit_slot = s;
            end else if (pos < list_count) begin
               s = list_next[s];
            end
         end
         if (hit_pos == 0) begin
            r.status = STATUS_MISS;
         end else if (kind == KIND_SEARCH) begin
            r.pos_from_head = count_type'(hit_pos);
            r.pos_from_tail = count_type'(list_count - hit_pos + 1);
         end else begin
            p = list_prev[hit_slot];
            n = list_next[hit_slot];
            if (hit_pos == 1) list_head = n;
            else list_next[p] = n;
            if (hit_pos == list_count) list_tail = p;
            else list_prev[n] = p;
            slot_taken[hit_slot] = 1'b0;
            list_count--;
         end
      end
      r.entry_total = count_type'(list_count);
      return r;
   endfunction

   // Offer one request transaction and predict its response once accepted.
   task automatic send_item(input kind_type kind, input value_type v);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.value <= v;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(apply_list_op(kind, v));
      items_sent++;
   endtask

   // Drop the request valid and wait until every response has been checked.
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
         error_count++;
      end
   endtask

   // Response side: random stalls, an occasional long hold, and the checks.
   initial begin : response_checker
      int stall;
      int long_holds_done;
      list_result_type want;
      long_holds_done = 0;
      rsp_bus.ready   = 1'b0;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (long_holds_done != long_holds_asked) begin
            stall = LONG_HOLD;
            long_holds_done++;
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         if (pending_results.size() == 0) begin
            $display("%0t: response transaction with no request pending", $realtime);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_bus.status));
            compare_field("pos_from_head", 32'(want.pos_from_head),
                          32'(rsp_bus.pos_from_head));
            compare_field("pos_from_tail", 32'(want.pos_from_tail),
                          32'(rsp_bus.pos_from_tail));
            compare_field("entry_total", 32'(want.entry_total), 32'(rsp_bus.entry_total));
            case (want.status)
               STATUS_FULL: full_seen++;
               STATUS_MISS: miss_seen++;
               default:     hit_seen++;
            endcase
            results_checked++;
         end
      end
   end

   // Empty-list misses, both ends, duplicates, and removal at head, middle and tail.
   task automatic test_directed();
      send_item(KIND_SEARCH, 32'sd5);
      send_item(KIND_REMOVE, 32'sd5);
      send_item(KIND_PUSH_BACK, 32'h7FFF_FFFF);
      send_item(KIND_PUSH_FRONT, 32'h8000_0000);
      send_item(KIND_PUSH_BACK, 32'sd0);
      send_item(KIND_PUSH_FRONT, -32'sd1);
      send_item(KIND_PUSH_BACK, 32'h7FFF_FFFF);
      send_item(KIND_SEARCH, 32'h7FFF_FFFF);
      send_item(KIND_SEARCH, -32'sd1);
      send_item(KIND_SEARCH, 32'sd0);
      send_item(KIND_SEARCH, 32'sd12345);
      send_item(KIND_REMOVE, 32'h7FFF_FFFF);
      send_item(KIND_SEARCH, 32'h7FFF_FFFF);
      send_item(KIND_REMOVE, -32'sd1);
      send_item(KIND_REMOVE, 32'h7FFF_FFFF);
      send_item(KIND_REMOVE, 32'sd7);
      send_item(KIND_SEARCH, 32'h8000_0000);
      send_item(KIND_REMOVE, 32'h8000_0000);
      send_item(KIND_REMOVE, 32'sd0);
      send_item(KIND_PUSH_FRONT, 32'h5555_5555);
      send_item(KIND_SEARCH, 32'h5555_5555);
      send_item(KIND_REMOVE, 32'h5555_5555);
      send_item(KIND_SEARCH, 32'h5555_5555);
      wait_drained();
   endtask

   // Fill every slot, overflow from both ends, then empty it by removing head or tail values.
   task automatic test_fill_and_overflow();
      kind_type push_kind;
      while (list_count < CAPACITY) begin
         push_kind = ($urandom_range(0, 1) == 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
         send_item(push_kind, value_type'($urandom));
      end
      send_item(KIND_PUSH_FRONT, 32'sd1);
      send_item(KIND_PUSH_BACK, 32'sd1);
      send_item(KIND_SEARCH, list_value[list_tail]);
      send_item(KIND_REMOVE, list_value[list_tail]);
      send_item(KIND_PUSH_BACK, 32'sd42);
      send_item(KIND_PUSH_FRONT, 32'sd43);
      while (list_count > 0) begin
         if ($urandom_range(0, 1) == 0) send_item(KIND_REMOVE, list_value[list_tail]);
         else send_item(KIND_REMOVE, list_value[list_head]);
      end
      wait_drained();
   endtask

   // Receiver holds off while requests keep coming, so the block backs up.
   task automatic test_backpressure();
      long_holds_asked++;
      for (int i = 0; i < 12; i++) begin
         send_item(kind_type'($urandom_range(0, 3)), value_pool[$urandom_range(0, 3)]);
      end
      wait_drained();
   endtask

   // Random operations in phases that alternately grow and shrink the list.
   task automatic test_random_ops();
      int roll;
      bit growing;
      kind_type kind;
      value_type v;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         growing = ((i / PHASE_ITEMS) % 2) == 0;
         no_idle = ((i / PHASE_ITEMS) % 4) == 2;
         roll = $urandom_range(0, 99);
         if (roll < (growing ? 65 : 25)) begin
            kind = ($urandom_range(0, 1) == 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
         end else if (roll < (growing ? 80 : 70)) begin
            kind = KIND_REMOVE;
         end else begin
            kind = KIND_SEARCH;
         end
         // Mostly pool values, so that removes and searches find duplicates.
         if ($urandom_range(0, 99) < 80) v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
         else v = value_type'($urandom);
         send_item(kind, v);
      end
      no_idle = 1'b0;
      wait_drained();
   endtask

   // Main sequence.
   initial begin
      items_sent       = 0;
      long_holds_asked = 0;
      no_idle          = 1'b0;
      list_head        = 0;
      list_tail        = 0;
      list_count       = 0;
      for (int i = 0; i < CAPACITY; i++) begin
         slot_taken[i] = 1'b0;
         list_value[i] = '0;
         list_prev[i]  = 0;
         list_next[i]  = 0;
      end
      value_pool[0] = 32'sd0;
      value_pool[1] = -32'sd1;
      value_pool[2] = 32'h8000_0000;
      value_pool[3] = 32'h7FFF_FFFF;
      value_pool[4] = 32'h5555_5555;
      value_pool[5] = 32'hAAAA_AAAA;
      value_pool[6] = 32'sd1;
      for (int i = 7; i < POOL_SIZE; i++) value_pool[i] = value_type'($urandom);

      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind  = KIND_PUSH_FRONT;
      req_bus.value = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_fill_and_overflow();
      test_backpressure();
      test_random_ops();
      test_fill_and_overflow();

      wait_drained();
      repeat (CAPACITY + 8) @(posedge clock);
      $display("Ran %0d requests with %0d responses checked: %0d done or found,",
               items_sent, results_checked, hit_seen);
      $display("%0d full-store drops, %0d misses, %0d errors.",
               full_seen, miss_seen, error_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/dll_pkg.sv
sv/dll_if.sv
sv/dll_ram.sv
sv/doubly_linked_list_engine.sv
tb/tb.sv
